>>> hw/rtl/dcs_pkg.sv
// Shared types, codes and constants for the drive command supervisor.
`timescale 1ns / 1ps
package dcs_pkg;

   localparam int DCS_TIME_WIDTH = 32;

   // input item kinds
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // integrity verdicts
   localparam logic [1:0] CHK_OK     = 2'd0;
   localparam logic [1:0] CHK_CRC    = 2'd1;
   localparam logic [1:0] CHK_REPEAT = 2'd2;
   localparam logic [1:0] CHK_LOST   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_CLOCK_OK = 2'd1;
   localparam logic [1:0] REG_LINK_UP  = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // vehicle and node states
   localparam logic [1:0] VS_FAILSAFE = 2'd0;
   localparam logic [1:0] VS_ARMED    = 2'd1;
   localparam logic [1:0] VS_DISARMED = 2'd2;
   localparam logic [1:0] NS_RUN      = 2'd0;
   localparam logic [1:0] NS_DEGRADED = 2'd1;
   localparam logic [1:0] NS_FAULT    = 2'd2;

   // fault bit positions
   localparam int F_BUS_OFF = 0;
   localparam int F_TIMEOUT = 3;
   localparam int F_E2E     = 4;
   localparam int F_CLOCK   = 7;

   localparam logic [7:0] ERR_MAX = 8'd255;

   // blink timing in ms
   localparam int PULSE_MS     = 300;
   localparam int PULSE_ON_MS  = 150;
   localparam int GAP_MS       = 900;
   localparam int HEART_MS     = 1000;
   localparam int HEART_ON_MS  = 60;
   localparam int DBL_MS       = 2 * PULSE_MS + GAP_MS;
   localparam int QUAD_MS      = 4 * PULSE_MS + GAP_MS;
   localparam int HEART_W      = $clog2(HEART_MS);
   localparam int DBL_W        = $clog2(DBL_MS);
   localparam int QUAD_W       = $clog2(QUAD_MS);
   localparam int DISARM_BIT   = 7;

   typedef struct packed {
      logic              kind;
      logic [1:0]        check_status;
      logic [6:0]        throttle_magnitude;
      logic [7:0]        brake_level;
      logic signed [7:0] steer_angle;
      logic              reverse_request;
      logic              armed_flag;
      logic              radio_link_ok;
      logic              bus_off_now;
   } req_word_type;

   typedef struct packed {
      logic signed [7:0] signed_drive;
      logic [6:0]        applied_throttle;
      logic [7:0]        applied_brake;
      logic signed [7:0] applied_steer;
      logic              reverse_lamp;
      logic [1:0]        vehicle_state;
      logic [7:0]        fault_flags;
      logic [7:0]        check_error_count;
      logic [1:0]        node_state;
      logic              status_led;
   } rsp_word_type;

endpackage

>>> hw/rtl/dcs_req_if.sv
// Input channel of the supervisor: valid, ready and one request word.
`timescale 1ns / 1ps
interface dcs_req_if
   import dcs_pkg::*;
();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/dcs_rsp_if.sv
// Result channel of the supervisor: valid, ready and one result word.
`timescale 1ns / 1ps
interface dcs_rsp_if
   import dcs_pkg::*;
();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/drive_command_supervisor_core.sv
// Drive command supervisor: gates driver commands and tracks node faults.
// Results are registered: output register, or skid stage while the output is held.
// Throughput: one word per cycle while the skid stage is empty; state update, freshness
// compare and blink phase compares all fit between the state and result registers.
// Reset (synchronous, active high) clears all state, empties the output register
// and the skid stage, and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
module drive_command_supervisor_core
   import dcs_pkg::*;
#(
   parameter int TIME_WIDTH = DCS_TIME_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   dcs_req_if.sink     req_chan,
   dcs_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   // configuration
   logic [15:0] timeout_ff;
   logic        clock_ok_ff;
   logic        link_up_ff;

   // supervisor state
   logic [TIME_WIDTH-1:0] ms_ff, ms_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;
   logic                  have_ff, have_in;
   logic [6:0]            thr_ff, thr_in;
   logic [7:0]            brk_ff, brk_in;
   logic [7:0]            str_ff, str_in;
   logic                  rev_ff, rev_in;
   logic                  arm_ff, arm_in;
   logic                  lnk_ff, lnk_in;
   logic [7:0]            err_ff, err_in;
   logic [7:0]            fault_ff, fault_in;
   logic [HEART_W-1:0]    heart_ff, heart_in;
   logic [DBL_W-1:0]      dbl_ff, dbl_in;
   logic [QUAD_W-1:0]     quad_ff, quad_in;

   // output register and skid stage
   rsp_word_type out_ff, skid_ff, word_in;
   logic         out_valid_ff, skid_valid_ff;

   req_word_type          req;
   logic                  fire_in, fire_out, cfg_wr;
   logic                  bad_frame, use_frame;
   logic [TIME_WIDTH-1:0] age;
   logic                  stale, cmd_ok, led;
   logic [7:0]            thr_ext;

   assign req      = req_chan.data;
   assign req_chan.ready = !skid_valid_ff;
   assign fire_in  = req_chan.valid && !skid_valid_ff;
   assign fire_out = out_valid_ff && rsp_chan.ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         REG_TIMEOUT:  csr_prdata = {16'd0, timeout_ff};
         REG_CLOCK_OK: csr_prdata = {31'd0, clock_ok_ff};
         REG_LINK_UP:  csr_prdata = {31'd0, link_up_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // next state for one request word
   always_comb begin
      ms_in    = ms_ff;
      heart_in = heart_ff;
      dbl_in   = dbl_ff;
      quad_in  = quad_ff;
      last_in  = last_ff;
      have_in  = have_ff;
      thr_in   = thr_ff;
      brk_in   = brk_ff;
      str_in   = str_ff;
      rev_in   = rev_ff;
      arm_in   = arm_ff;
      lnk_in   = lnk_ff;
      err_in   = err_ff;
      fault_in = fault_ff;

      if (!clock_ok_ff) fault_in[F_CLOCK] = 1'b1;

      bad_frame = (req.check_status == CHK_CRC) || (req.check_status == CHK_REPEAT)
                  || (req.check_status == CHK_LOST);
      use_frame = req.check_status != CHK_CRC && req.check_status != CHK_REPEAT;

      if (req.kind == KIND_TICK) begin
         if (ms_ff == TIME_MAX) begin
            // counter wrap restarts every blink phase
            ms_in    = '0;
            heart_in = '0;
            dbl_in   = '0;
            quad_in  = '0;
         end else begin
            ms_in    = ms_ff + 1'b1;
            heart_in = (heart_ff == HEART_W'(HEART_MS - 1)) ? '0 : heart_ff + 1'b1;
            dbl_in   = (dbl_ff == DBL_W'(DBL_MS - 1)) ? '0 : dbl_ff + 1'b1;
            quad_in  = (quad_ff == QUAD_W'(QUAD_MS - 1)) ? '0 : quad_ff + 1'b1;
         end
      end else if (link_up_ff) begin
         if (bad_frame) begin
            if (err_ff != ERR_MAX) err_in = err_ff + 8'd1;
            fault_in[F_E2E] = 1'b1;
         end
         if (use_frame) begin
            thr_in  = req.throttle_magnitude;
            brk_in  = req.brake_level;
            str_in  = req.steer_angle;
            rev_in  = req.reverse_request;
            arm_in  = req.armed_flag;
            lnk_in  = req.radio_link_ok;
            last_in = ms_ff;
            have_in = 1'b1;
         end
      end

      fault_in[F_BUS_OFF] = req.bus_off_now;

      age    = ms_in - last_in;
      stale  = age >= TIME_WIDTH'(timeout_ff);
      cmd_ok = have_in && !stale && lnk_in;

      if (have_in && stale) fault_in[F_TIMEOUT] = 1'b1;
      else if (cmd_ok)      fault_in[F_TIMEOUT] = 1'b0;

      thr_ext = {1'b0, thr_in};
      word_in = '0;
      if (cmd_ok && arm_in) begin
         if (brk_in == 8'd0) begin
            word_in.applied_throttle = thr_in;
            word_in.signed_drive     = rev_in ? 8'(8'd0 - thr_ext) : thr_ext;
         end
         word_in.applied_brake = brk_in;
         word_in.applied_steer = str_in;
         word_in.reverse_lamp  = rev_in;
      end

      if (!cmd_ok)     word_in.vehicle_state = VS_FAILSAFE;
      else if (arm_in) word_in.vehicle_state = VS_ARMED;
      else             word_in.vehicle_state = VS_DISARMED;

      word_in.fault_flags       = fault_in;
      word_in.check_error_count = err_in;

      if (req.bus_off_now)       word_in.node_state = NS_FAULT;
      else if (fault_in != 8'd0) word_in.node_state = NS_DEGRADED;
      else                       word_in.node_state = NS_RUN;

      // pulse windows: on for the first half of each pulse slot in the burst
      if (!clock_ok_ff)
         led = (dbl_in < DBL_W'(PULSE_ON_MS))
               || (dbl_in >= DBL_W'(PULSE_MS) && dbl_in < DBL_W'(PULSE_MS + PULSE_ON_MS));
      else if (!link_up_ff)
         led = (quad_in < QUAD_W'(PULSE_ON_MS))
               || (quad_in >= QUAD_W'(PULSE_MS)
                   && quad_in < QUAD_W'(PULSE_MS + PULSE_ON_MS))
               || (quad_in >= QUAD_W'(2 * PULSE_MS)
                   && quad_in < QUAD_W'(2 * PULSE_MS + PULSE_ON_MS))
               || (quad_in >= QUAD_W'(3 * PULSE_MS)
                   && quad_in < QUAD_W'(3 * PULSE_MS + PULSE_ON_MS));
      else if (!cmd_ok)
         led = heart_in < HEART_W'(HEART_ON_MS);
      else if (arm_in)
         led = 1'b1;
      else
         led = ms_in[DISARM_BIT];
      word_in.status_led = led;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         clock_ok_ff   <= 1'b1;
         link_up_ff    <= 1'b1;
         ms_ff         <= '0;
         last_ff       <= '0;
         have_ff       <= 1'b0;
         thr_ff        <= '0;
         brk_ff        <= '0;
         str_ff        <= '0;
         rev_ff        <= 1'b0;
         arm_ff        <= 1'b0;
         lnk_ff        <= 1'b0;
         err_ff        <= '0;
         fault_ff      <= '0;
         heart_ff      <= '0;
         dbl_ff        <= '0;
         quad_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            case (csr_paddr[3:2])
               REG_TIMEOUT: timeout_ff <= csr_pwdata[15:0];
               REG_CLOCK_OK: begin
                  clock_ok_ff <= csr_pwdata[0];
                  if (!csr_pwdata[0]) fault_ff[F_CLOCK] <= 1'b1;
               end
               REG_LINK_UP: link_up_ff <= csr_pwdata[0];
               default: ;
            endcase
         end else if (fire_in) begin
            ms_ff    <= ms_in;
            last_ff  <= last_in;
            have_ff  <= have_in;
            thr_ff   <= thr_in;
            brk_ff   <= brk_in;
            str_ff   <= str_in;
            rev_ff   <= rev_in;
            arm_ff   <= arm_in;
            lnk_ff   <= lnk_in;
            err_ff   <= err_in;
            fault_ff <= fault_in;
            heart_ff <= heart_in;
            dbl_ff   <= dbl_in;
            quad_ff  <= quad_in;
         end

         // result word flow: output register first, skid when it is held
         if (fire_out) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else if (fire_in) begin
               out_ff <= word_in;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (fire_in) begin
            if (!out_valid_ff) begin
               out_ff       <= word_in;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= word_in;
               skid_valid_ff <= 1'b1;
            end
         end
      end
   end

endmodule

>>> tb/drive_command_supervisor_core_test.sv
// Self-checking testbench for the drive command supervisor core.
`timescale 1ns / 1ps
module drive_command_supervisor_core_test
   import dcs_pkg::*;
();

   localparam int RUN_LIMIT_NS = 5_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dcs_req_if req_bus ();
   dcs_rsp_if rsp_bus ();

   drive_command_supervisor_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // supervisor mirror: registers and state
   logic [15:0]               cfg_timeout;
   logic                      cfg_clock_ok;
   logic                      cfg_link_up;
   logic [DCS_TIME_WIDTH-1:0] now_ms;
   logic [DCS_TIME_WIDTH-1:0] cmd_stamp;
   logic                      cmd_held;
   logic [6:0]                cmd_throttle;
   logic [7:0]                cmd_brake;
   logic signed [7:0]         cmd_steer;
   logic                      cmd_reverse;
   logic                      cmd_armed;
   logic                      cmd_link;
   logic [7:0]                err_count;
   logic [7:0]                faults;

   rsp_word_type drive_outputs_due[$];
   int           mismatch_count   = 0;
   bit           src_gaps         = 1'b0;
   bit           sink_stalls      = 1'b0;
   int           sink_hold_cycles = 0;

   function automatic logic command_stale();
      logic [DCS_TIME_WIDTH-1:0] age;
      age = now_ms - cmd_stamp;
      return age >= cfg_timeout;
   endfunction

   function automatic logic command_live();
      return cmd_held && !command_stale() && cmd_link;
   endfunction

   function automatic void note_integrity_error();
      if (err_count != ERR_MAX) err_count++;
      faults[F_E2E] = 1'b1;
   endfunction

   function automatic logic pulse_train(logic [DCS_TIME_WIDTH-1:0] ms, int unsigned pulses);
      longint unsigned burst;
      longint unsigned phase;
      burst = pulses * PULSE_MS;
      phase = ms % (burst + GAP_MS);
      return phase < burst && phase % PULSE_MS < PULSE_ON_MS;
   endfunction

   // Advances the mirror by one accepted word and returns the word it must produce.
   function automatic rsp_word_type compute_drive_output(req_word_type w);
      rsp_word_type r;
      logic         live;
      logic [7:0]   drive;
      r = '0;
      if (!cfg_clock_ok) faults[F_CLOCK] = 1'b1;

      if (w.kind == KIND_TICK) begin
         now_ms = now_ms + 1'b1;
      end else if (cfg_link_up) begin
         if (w.check_status == CHK_CRC || w.check_status == CHK_REPEAT) begin
            note_integrity_error();
         end else begin
            if (w.check_status == CHK_LOST) note_integrity_error();
            cmd_throttle = w.throttle_magnitude;
            cmd_brake    = w.brake_level;
            cmd_steer    = w.steer_angle;
            cmd_reverse  = w.reverse_request;
            cmd_armed    = w.armed_flag;
            cmd_link     = w.radio_link_ok;
            cmd_stamp    = now_ms;
            cmd_held     = 1'b1;
         end
      end

      faults[F_BUS_OFF] = w.bus_off_now;
      if (cmd_held && command_stale()) faults[F_TIMEOUT] = 1'b1;
      else if (command_live()) faults[F_TIMEOUT] = 1'b0;

      live = command_live();
      if (live && cmd_armed) begin
         r.applied_brake = cmd_brake;
         r.applied_steer = cmd_steer;
         r.reverse_lamp  = cmd_reverse;
         if (cmd_brake == 8'd0) begin
            drive = {1'b0, cmd_throttle};
            if (cmd_reverse) drive = 8'd0 - drive;
            r.applied_throttle = cmd_throttle;
            r.signed_drive     = drive;
         end
      end

      r.vehicle_state = !live ? VS_FAILSAFE : (cmd_armed ? VS_ARMED : VS_DISARMED);
      r.node_state = w.bus_off_now ? NS_FAULT : (faults != 8'd0 ? NS_DEGRADED : NS_RUN);
      r.fault_flags       = faults;
      r.check_error_count = err_count;

      if (!cfg_clock_ok) r.status_led = pulse_train(now_ms, 2);
      else if (!cfg_link_up) r.status_led = pulse_train(now_ms, 4);
      else if (!live) r.status_led = (now_ms % HEART_MS) < HEART_ON_MS;
      else if (cmd_armed) r.status_led = 1'b1;
      else r.status_led = now_ms[DISARM_BIT];
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      mismatch_count++;
      $display("%0t ns: mismatch, %s", $time, what);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got 'h%0h, want 'h%0h", name, got, want));
   endtask

   always @(posedge clock) begin : result_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.data;
         if (drive_outputs_due.size() == 0) begin
            flag_mismatch("result word with no command word outstanding");
         end else begin
            want = drive_outputs_due.pop_front();
            check_field("signed_drive", got.signed_drive, want.signed_drive);
            check_field("applied_throttle", got.applied_throttle, want.applied_throttle);
            check_field("applied_brake", got.applied_brake, want.applied_brake);
            check_field("applied_steer", got.applied_steer, want.applied_steer);
            check_field("reverse_lamp", got.reverse_lamp, want.reverse_lamp);
            check_field("vehicle_state", got.vehicle_state, want.vehicle_state);
            check_field("fault_flags", got.fault_flags, want.fault_flags);
            check_field("check_error_count", got.check_error_count, want.check_error_count);
            check_field("node_state", got.node_state, want.node_state);
            check_field("status_led", got.status_led, want.status_led);
         end
      end
   end

   // result side pacing: random stall bursts, or one long hold-off on request
   initial begin : sink_pacing
      int n;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_cycles > 0) begin
            n = sink_hold_cycles;
            sink_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(req_word_type w);
      if (src_gaps && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.data  <= w;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      drive_outputs_due.push_back(compute_drive_output(w));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (drive_outputs_due.size() != 0);
   endtask

   // setup + access write, then a read of the same register
   task automatic write_register(logic [1:0] index, logic [31:0] value);
      logic [31:0] width_mask;
      logic [31:0] readback;
      case (index)
         REG_TIMEOUT: begin
            width_mask  = 32'h0000_FFFF;
            cfg_timeout = value[15:0];
         end
         REG_CLOCK_OK: begin
            width_mask   = 32'h1;
            cfg_clock_ok = value[0];
            if (!value[0]) faults[F_CLOCK] = 1'b1;
         end
         default: begin
            width_mask  = 32'h1;
            cfg_link_up = value[0];
         end
      endcase
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if ((readback & width_mask) !== (value & width_mask))
         flag_mismatch($sformatf("register %0d read 'h%0h after writing 'h%0h",
                                 index, readback, value));
   endtask

   function automatic req_word_type frame_word(logic [1:0] status, logic [6:0] throttle,
                                               logic [7:0] brake, logic signed [7:0] steer,
                                               logic reverse, logic armed, logic link,
                                               logic bus_off);
      req_word_type w;
      w.kind               = KIND_FRAME;
      w.check_status       = status;
      w.throttle_magnitude = throttle;
      w.brake_level        = brake;
      w.steer_angle        = steer;
      w.reverse_request    = reverse;
      w.armed_flag         = armed;
      w.radio_link_ok      = link;
      w.bus_off_now        = bus_off;
      return w;
   endfunction

   function automatic req_word_type tick_word(logic bus_off);
      req_word_type w;
      w      = frame_word(CHK_OK, 7'd0, 8'd0, 8'sd0, 1'b0, 1'b0, 1'b0, bus_off);
      w.kind = KIND_TICK;
      return w;
   endfunction

   function automatic req_word_type random_word(int tick_pct, int bad_pct);
      req_word_type w;
      w.kind = ($urandom_range(0, 99) < tick_pct) ? KIND_TICK : KIND_FRAME;
      w.check_status = ($urandom_range(0, 99) < bad_pct) ?
                       2'($urandom_range(CHK_CRC, CHK_LOST)) : CHK_OK;
      case ($urandom_range(0, 7))
         0: w.throttle_magnitude = '0;
         1: w.throttle_magnitude = '1;
         default: w.throttle_magnitude = 7'($urandom);
      endcase
      w.brake_level     = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
      w.steer_angle     = 8'($urandom);
      w.reverse_request = 1'($urandom);
      w.armed_flag      = $urandom_range(0, 9) != 0;
      w.radio_link_ok   = $urandom_range(0, 9) != 0;
      w.bus_off_now     = $urandom_range(0, 9) == 0;
      return w;
   endfunction

   task automatic run_random(int count, int tick_pct, int bad_pct);
      repeat (count) send_word(random_word(tick_pct, bad_pct));
   endtask

   task automatic test_frame_gating();
      write_register(REG_TIMEOUT, 32'd3);
      send_word(tick_word(1'b1));                                      // bus-off, nothing held
      send_word(frame_word(CHK_OK, 7'd127, 8'd0, -8'sd128, 1'b0, 1'b1, 1'b1, 1'b0));
      send_word(frame_word(CHK_OK, 7'd127, 8'd0, 8'sd127, 1'b1, 1'b1, 1'b1, 1'b0));
      send_word(frame_word(CHK_OK, 7'd100, 8'd255, 8'sd5, 1'b1, 1'b1, 1'b1, 1'b0));
      send_word(frame_word(CHK_OK, 7'd0, 8'd1, 8'sd0, 1'b0, 1'b1, 1'b1, 1'b0));
      send_word(frame_word(CHK_OK, 7'd60, 8'd0, -8'sd1, 1'b0, 1'b0, 1'b1, 1'b0)); // disarmed
      send_word(frame_word(CHK_OK, 7'd60, 8'd0, -8'sd1, 1'b0, 1'b1, 1'b0, 1'b0)); // radio down
      send_word(frame_word(CHK_CRC, 7'd10, 8'd0, 8'sd10, 1'b0, 1'b1, 1'b1, 1'b0));
      send_word(frame_word(CHK_REPEAT, 7'd20, 8'd0, 8'sd20, 1'b0, 1'b1, 1'b1, 1'b0));
      // lost sequence is counted but the frame still drives
      send_word(frame_word(CHK_LOST, 7'd30, 8'd0, 8'sd30, 1'b1, 1'b1, 1'b1, 1'b0));
      repeat (3) send_word(tick_word(1'b0));
      send_word(frame_word(CHK_OK, 7'd45, 8'd0, 8'sd12, 1'b0, 1'b1, 1'b1, 1'b1));
      send_word(tick_word(1'b0));
      drain_results();
   endtask

   task automatic test_link_and_timeout_limits();
      write_register(REG_LINK_UP, 32'd0);
      send_word(frame_word(CHK_CRC, 7'd5, 8'd0, 8'sd5, 1'b0, 1'b1, 1'b1, 1'b0));
      send_word(frame_word(CHK_OK, 7'd90, 8'd0, 8'sd3, 1'b0, 1'b1, 1'b1, 1'b0));
      send_word(tick_word(1'b0));
      drain_results();
      write_register(REG_LINK_UP, 32'd1);
      // zero timeout: a frame is stale as soon as it lands
      write_register(REG_TIMEOUT, 32'd0);
      send_word(frame_word(CHK_OK, 7'd90, 8'd0, 8'sd3, 1'b0, 1'b1, 1'b1, 1'b0));
      drain_results();
      write_register(REG_TIMEOUT, 32'hFFFF);
      send_word(frame_word(CHK_OK, 7'd90, 8'd0, 8'sd3, 1'b0, 1'b1, 1'b1, 1'b0));
      send_word(tick_word(1'b0));
      drain_results();
   endtask

   task automatic test_random_traffic();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      write_register(REG_TIMEOUT, 32'd1);
      run_random(100, 50, 20);
      drain_results();
      write_register(REG_TIMEOUT, 32'd5);
      run_random(130, 60, 15);
      drain_results();
      write_register(REG_TIMEOUT, 32'hFFFF);
      sink_stalls = 1'b0;
      run_random(90, 50, 25);
      drain_results();
      write_register(REG_TIMEOUT, 32'd20);
      write_register(REG_LINK_UP, 32'd0);
      src_gaps    = 1'b0;
      sink_stalls = 1'b1;
      run_random(90, 60, 30);
      drain_results();
      write_register(REG_LINK_UP, 32'd1);
      write_register(REG_TIMEOUT, 32'd100);
      src_gaps = 1'b1;
      run_random(100, 70, 15);
      drain_results();
   endtask

   task automatic test_backpressure();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      write_register(REG_TIMEOUT, 32'd4);
      sink_hold_cycles = 50;
      run_random(30, 40, 20);
      // sender sits idle until every result is back
      drain_results();
      run_random(10, 50, 10);
      drain_results();
   endtask

   task automatic test_clock_fault();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      write_register(REG_CLOCK_OK, 32'd0);
      send_word(tick_word(1'b0));
      send_word(frame_word(CHK_OK, 7'd70, 8'd0, 8'sd9, 1'b0, 1'b1, 1'b1, 1'b0));
      run_random(40, 80, 20);
      drain_results();
      // clock and link both bad: double blink wins
      write_register(REG_LINK_UP, 32'd0);
      run_random(40, 80, 20);
      drain_results();
      // clock fault bit stays set after recovery
      write_register(REG_CLOCK_OK, 32'd1);
      send_word(tick_word(1'b0));
      run_random(40, 80, 20);
      drain_results();
      write_register(REG_LINK_UP, 32'd1);
   endtask

   task automatic test_error_saturation();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      write_register(REG_TIMEOUT, 32'd6);
      run_random(280, 5, 95);
      drain_results();
   endtask

   initial begin : test_sequence
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.data   <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      cfg_timeout    = TIMEOUT_RESET;
      cfg_clock_ok   = 1'b1;
      cfg_link_up    = 1'b1;
      now_ms         = '0;
      cmd_stamp      = '0;
      cmd_held       = 1'b0;
      cmd_throttle   = '0;
      cmd_brake      = '0;
      cmd_steer      = '0;
      cmd_reverse    = 1'b0;
      cmd_armed      = 1'b0;
      cmd_link       = 1'b0;
      err_count      = '0;
      faults         = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_frame_gating();
      test_link_and_timeout_limits();
      test_random_traffic();
      test_backpressure();
      test_clock_fault();
      test_error_saturation();

      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/dcs_pkg.sv
hw/rtl/dcs_req_if.sv
hw/rtl/dcs_rsp_if.sv
hw/rtl/drive_command_supervisor_core.sv
tb/drive_command_supervisor_core_test.sv
